[sv/grr_pkg.sv]
// shared types, font table and character mapping for the glyph row rasterizer
package grr_pkg;

    localparam int CELL_W = 10;
    localparam int CELL_H = 14;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_QUEST = 7'h3f;
    localparam logic [6:0] CH_EXCL  = 7'h21;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_COMMA = 7'h2c;
    localparam logic [6:0] CH_DASH  = 7'h2d;
    localparam logic [6:0] CH_SLASH = 7'h2f;
    localparam logic [6:0] CH_COLON = 7'h3a;

    localparam logic [5:0] G_BLANK = 6'd0;
    localparam logic [5:0] G_DIGIT = 6'd1;
    localparam logic [5:0] G_UPPER = 6'd11;
    localparam logic [5:0] G_PUNCT = 6'd37;
    localparam logic [5:0] G_QUEST = 6'd43;

    localparam int GLYPH_COUNT = 44;

    typedef logic [4:0][6:0] glyph_t;

    // one decoded character: clipped span, row range and glyph bits
    typedef struct packed {
        glyph_t             glyph;
        logic [7:0]         x0;
        logic [7:0]         x1;
        logic [3:0]         lead;
        logic [3:0]         len;
        logic signed [10:0] y;
        logic [3:0]         row_first;
        logic [3:0]         row_last;
        logic [15:0]        fg;
        logic               has_rows;
    } item_t;

    localparam logic [6:0] FONT [0:GLYPH_COUNT-1][0:4] = '{
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, '{7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
        '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4b, 7'h31},
        '{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        '{7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1e},
        '{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
        '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
        '{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
        '{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
        '{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
        '{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
        '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
        '{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
        '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
        '{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
        '{7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        '{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43},
        '{7'h00, 7'h00, 7'h5f, 7'h00, 7'h00}, '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00},
        '{7'h00, 7'h40, 7'h30, 7'h00, 7'h00}, '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08},
        '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02}, '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00},
        '{7'h02, 7'h01, 7'h51, 7'h09, 7'h06}
    };

    // codepoint to font index: fold lower case, non-printables and unmapped characters become '?'
    function automatic logic [5:0] glyph_index(input logic [20:0] cp);
        logic [6:0] ch;
        logic [5:0] idx;
        if (cp >= 21'h61 && cp <= 21'h7a) begin
            ch = 7'(cp - 21'd32);
        end else if (cp >= 21'h20 && cp <= 21'h7e) begin
            ch = cp[6:0];
        end else begin
            ch = CH_QUEST;
        end
        if (ch == CH_SPACE) begin
            idx = G_BLANK;
        end else if (ch >= 7'h30 && ch <= 7'h39) begin
            idx = G_DIGIT + 6'(ch - 7'h30);
        end else if (ch >= 7'h41 && ch <= 7'h5a) begin
            idx = G_UPPER + 6'(ch - 7'h41);
        end else begin
            case (ch)
                CH_EXCL:  idx = G_PUNCT + 6'd0;
                CH_DOT:   idx = G_PUNCT + 6'd1;
                CH_COMMA: idx = G_PUNCT + 6'd2;
                CH_DASH:  idx = G_PUNCT + 6'd3;
                CH_SLASH: idx = G_PUNCT + 6'd4;
                CH_COLON: idx = G_PUNCT + 6'd5;
                default:  idx = G_QUEST;
            endcase
        end
        return idx;
    endfunction

endpackage

[sv/grr_setup.sv]
// character decode, horizontal clipping and visible row range for one request
module grr_setup #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic [20:0]         codepoint,
    input  logic signed [12:0]  x_left,
    input  logic signed [10:0]  y_top,
    input  logic [15:0]         color,
    output grr_pkg::item_t      item
);
    import grr_pkg::*;

    localparam logic signed [13:0] WIDTH_S  = 14'(SCREEN_WIDTH);
    localparam logic signed [12:0] HMAX_S   = 13'(SCREEN_HEIGHT - 1);
    localparam logic signed [13:0] CELL_W_S = 14'(CELL_W);
    localparam logic signed [12:0] LAST_S   = 13'(CELL_H - 1);

    logic [5:0]         gidx;
    logic signed [13:0] xs;
    logic signed [13:0] x_end;
    logic signed [13:0] x0;
    logic signed [13:0] x1;
    logic signed [13:0] lead_w;
    logic signed [13:0] len_w;
    logic signed [12:0] ys;
    logic signed [12:0] hy;
    logic signed [12:0] rf;
    logic signed [12:0] rl;

    always_comb begin
        gidx = glyph_index(codepoint);
        for (int c = 0; c < 5; c++) begin
            item.glyph[c] = FONT[gidx][c];
        end

        xs     = 14'(x_left);
        x_end  = xs + CELL_W_S;
        x0     = (xs < 0) ? 14'sd0 : xs;
        x1     = (x_end > WIDTH_S) ? WIDTH_S : x_end;
        lead_w = x0 - xs;
        len_w  = x1 - x0;

        // rows of the cell that land on screen
        ys = 13'(y_top);
        hy = HMAX_S - ys;
        rf = (ys < 0) ? -ys : 13'sd0;
        rl = (hy > LAST_S) ? LAST_S : hy;

        item.x0        = x0[7:0];
        item.x1        = x1[7:0];
        item.lead      = lead_w[3:0];
        item.len       = len_w[3:0];
        item.y         = y_top;
        item.row_first = rf[3:0];
        item.row_last  = rl[3:0];
        item.fg        = {color[7:0], color[15:8]};
        item.has_rows  = (x1 > x0) && (rl >= 0) && (rf <= rl);
    end

endmodule

[sv/grr_row_seq.sv]
// item register, row counter and output register that emit one span per cycle while the output is not stalled
module grr_row_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  grr_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     row_y,
    output logic [7:0]     span_start,
    output logic [7:0]     span_end,
    output logic [9:0]     pixel_mask,
    output logic [15:0]    fg_word,
    output logic           last_row
);
    import grr_pkg::*;

    logic        busy_reg;
    logic [3:0]  row_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    logic [7:0]  row_y_reg;
    logic [7:0]  span_start_reg;
    logic [7:0]  span_end_reg;
    logic [9:0]  pixel_mask_reg;
    logic [15:0] fg_word_reg;
    logic        last_row_reg;

    logic              adv;
    logic              at_last;
    logic              accept;
    logic [9:0]        pattern;
    logic [10:0]       len_mask;
    logic [7:0]        row_y_next;
    logic [9:0]        pixel_mask_next;
    logic signed [10:0] sy;

    always_comb begin
        adv      = busy_reg && (!out_valid_reg || out_ready);
        at_last  = (row_reg == item_reg.row_last);
        in_ready = !busy_reg || (adv && at_last);
        accept   = in_valid && in_ready;

        // doubled glyph row, then shifted to the clipped start
        for (int c = 0; c < CELL_W; c++) begin
            pattern[c] = item_reg.glyph[c / 2][row_reg[3:1]];
        end
        len_mask        = (11'd1 << item_reg.len) - 11'd1;
        pixel_mask_next = (pattern >> item_reg.lead) & len_mask[9:0];
        sy              = item_reg.y + 11'(row_reg);
        row_y_next      = sy[7:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            row_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept && in_item.has_rows) begin
                busy_reg <= 1'b1;
                row_reg  <= in_item.row_first;
            end else if (adv && at_last) begin
                busy_reg <= 1'b0;
            end else if (adv) begin
                row_reg <= row_reg + 4'd1;
            end

            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (adv) begin
            row_y_reg      <= row_y_next;
            span_start_reg <= item_reg.x0;
            span_end_reg   <= item_reg.x1;
            pixel_mask_reg <= pixel_mask_next;
            fg_word_reg    <= item_reg.fg;
            last_row_reg   <= at_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_y      = row_y_reg;
    assign span_start = span_start_reg;
    assign span_end   = span_end_reg;
    assign pixel_mask = pixel_mask_reg;
    assign fg_word    = fg_word_reg;
    assign last_row   = last_row_reg;

    // the counter never runs past the last visible row
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (row_reg <= item_reg.row_last))
        else $error("row counter beyond last visible row");

    // a new request only lands while the current one is idle or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy_reg) |-> (adv && at_last))
        else $error("request accepted mid character");

    // finishing a character shows a span marked last on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && at_last) |=> (out_valid_reg && last_row_reg))
        else $error("final span not flagged last");

    // output never shows a span bit beyond its length
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> ((pixel_mask_next & ~len_mask[9:0]) == 10'd0))
        else $error("mask bit beyond span");

endmodule

[sv/glyph_row_rasterizer_top.sv]
// top level of the glyph row rasterizer: 5x7 font drawn doubled as clipped row spans
//
//  channel | tdata bits, low first                               | tuser | tlast
//  s_axis  | codepoint 21, x_left 13, y_top 11, color 16 (64)   | -     | -
//  m_axis  | row_y 8, span_start 8, span_end 8, pixel_mask 10,  | -     | last_row
//          | fg_word 16 (56)                                    |       |
//
// one span leaves per cycle while m_axis_tready does not stall the output; a character gives one
// span per visible row (1 to 14), set by the row counter stepping through the cell
// a character with no visible rows is accepted and gives no span
// the next request is taken in the cycle the last span of the current one is loaded
// reset clears the busy flag and the output valid; no clearing pass
// m_axis_tready low while m_axis_tvalid is high holds the output register and freezes the row counter
module glyph_row_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // codepoint, x_left, y_top, color
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // row_y, span_start, span_end, pixel_mask, fg_word
    output logic        m_axis_tlast
);
    import grr_pkg::*;

    item_t       item;
    logic [7:0]  row_y;
    logic [7:0]  span_start;
    logic [7:0]  span_end;
    logic [9:0]  pixel_mask;
    logic [15:0] fg_word;

    grr_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_setup (
        .codepoint (s_axis_tdata[20:0]),
        .x_left    (s_axis_tdata[33:21]),
        .y_top     (s_axis_tdata[44:34]),
        .color     (s_axis_tdata[60:45]),
        .item      (item)
    );

    grr_row_seq u_row_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .row_y      (row_y),
        .span_start (span_start),
        .span_end   (span_end),
        .pixel_mask (pixel_mask),
        .fg_word    (fg_word),
        .last_row   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, fg_word, pixel_mask, span_end, span_start, row_y};

endmodule
